// ===== sv/gcd_pkg.sv =====
// Shared constants, widths and the arctangent table for the great circle distance unit.
// No dependencies; every other file depends on this package.
`default_nettype none

package gcd_pkg;

	localparam int CORDIC_STEPS = 24;

	// Field and datapath widths.
	localparam int LAT_W   = 24;
	localparam int LON_W   = 25;
	localparam int ANG_W   = 26;
	localparam int RED_W   = ANG_W + 2;
	localparam int FOLD_W  = 24;
	localparam int RAD_W   = 48;
	localparam int CW      = 34;
	localparam int TRIG_W  = 32;
	localparam int SQ_W    = 62;
	localparam int SQ_STEPS = 31;
	localparam int ANGR_W  = 33;
	localparam int DPR_W   = 22;
	localparam int DEG_W   = 25;
	localparam int MPD_W   = 16;
	localparam int DIST_W  = 24;
	localparam int RADM_W  = 23;

	localparam logic signed [RED_W-1:0] DEG360 = 28'sd23592960;
	localparam logic signed [RED_W-1:0] DEG180 = 28'sd11796480;
	localparam logic signed [RED_W-1:0] DEG90  = 28'sd5898240;

	localparam logic signed [25:0] RAD_PER_DEG  = 26'sd18740330;
	localparam logic [DPR_W-1:0]   DEG_PER_RAD  = 22'd3754936;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;
	localparam logic [MPD_W-1:0]   MPD_RESET    = 16'd23270;

	// Arctangent of 2^-i in Q30 radians.
	function automatic logic signed [CW-1:0] atan_q30(input int i);
		logic signed [CW-1:0] t;
		case (i)
			0: t = 34'sd843314857;
			1: t = 34'sd497837829;
			2: t = 34'sd263043837;
			3: t = 34'sd133525159;
			4: t = 34'sd67021687;
			5: t = 34'sd33543516;
			6: t = 34'sd16775851;
			7: t = 34'sd8388437;
			8: t = 34'sd4194283;
			9: t = 34'sd2097149;
			default: t = (i <= 30) ? (CW'(1) << (30 - i)) : '0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== sv/gcd_if.sv =====
// Stream interfaces for the point-pair input channel and the distance result channel.
// Depends on gcd_pkg for field widths.
`default_nettype none

interface gcd_in_if;
	logic valid;
	logic ready;
	logic signed [gcd_pkg::LAT_W-1:0] from_latitude;
	logic signed [gcd_pkg::LON_W-1:0] from_longitude;
	logic signed [gcd_pkg::LAT_W-1:0] to_latitude;
	logic signed [gcd_pkg::LON_W-1:0] to_longitude;

	modport source(output valid, from_latitude, from_longitude, to_latitude, to_longitude,
		input ready);
	modport sink(input valid, from_latitude, from_longitude, to_latitude, to_longitude,
		output ready);
endinterface

interface gcd_out_if;
	logic valid;
	logic ready;
	logic [gcd_pkg::DIST_W-1:0] distance_miles;
	logic [gcd_pkg::RADM_W-1:0] radius_miles;

	modport source(output valid, distance_miles, radius_miles, input ready);
	modport sink(input valid, distance_miles, radius_miles, output ready);
endinterface

`default_nettype wire

// ===== sv/gcd_sincos.sv =====
// Pipelined sine and cosine of an angle in Q16 degrees: wrap, fold, radian scaling
// and one CORDIC rotation stage per register. Depends on gcd_pkg.
`default_nettype none

module gcd_sincos (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_i,
	input  logic signed [gcd_pkg::ANG_W-1:0] deg,
	output logic vld_o,
	output logic signed [gcd_pkg::TRIG_W-1:0] sin_q,
	output logic signed [gcd_pkg::TRIG_W-1:0] cos_q
);
	import gcd_pkg::*;

	localparam int N = CORDIC_STEPS;

	logic signed [RED_W-1:0] r_ext, r_wrap, r_fold;
	logic neg_fold;

	logic signed [FOLD_W-1:0] r_s1;
	logic neg_s1, v_s1;
	logic signed [RAD_W-1:0] rad_s2;
	logic neg_s2, v_s2;

	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [CW-1:0] z_s [0:N];
	logic neg_s [0:N];
	logic v_s [0:N];

	// Bring the angle into [-180,180), then fold into [-90,90] with a cosine sign flip.
	always_comb begin
		r_ext = RED_W'(deg);
		r_wrap = r_ext;
		if (r_ext >= DEG180) begin
			r_wrap = r_ext - DEG360;
		end else if (r_ext < -DEG180) begin
			r_wrap = r_ext + DEG360;
		end
		r_fold = r_wrap;
		neg_fold = 1'b0;
		if (r_wrap > DEG90) begin
			r_fold = DEG180 - r_wrap;
			neg_fold = 1'b1;
		end else if (r_wrap < -DEG90) begin
			r_fold = -DEG180 - r_wrap;
			neg_fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= FOLD_W'(r_fold);
			neg_s1 <= neg_fold;
			rad_s2 <= r_s1 * RAD_PER_DEG;
			neg_s2 <= neg_s1;
			z_s[0] <= CW'((rad_s2 + 48'sd32768) >>> 16);
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			neg_s[0] <= neg_s2;
			sin_q <= TRIG_W'(y_s[N]);
			cos_q <= neg_s[N] ? TRIG_W'(-x_s[N]) : TRIG_W'(x_s[N]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s[0] <= 1'b0;
			vld_o <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_i;
			v_s2 <= v_s1;
			v_s[0] <= v_s2;
			vld_o <= v_s[N];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(i);
				end
				neg_s[i+1] <= neg_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/gcd_acos.sv =====
// Pipelined arccosine of a Q30 value: one square-root digit per stage for sqrt(1-c^2),
// then CORDIC vectoring of (|c|, sqrt) and the quadrant fix. Depends on gcd_pkg.
`default_nettype none

module gcd_acos (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_i,
	input  logic signed [gcd_pkg::TRIG_W-1:0] cval,
	output logic vld_o,
	output logic [gcd_pkg::ANGR_W-1:0] ang_q
);
	import gcd_pkg::*;

	localparam int N = CORDIC_STEPS;
	localparam int M = SQ_STEPS;

	logic signed [63:0] csq_s1;
	logic [TRIG_W-2:0] ax_s1;
	logic neg_s1, v_s1;

	logic [SQ_W-1:0] n_s [0:M];
	logic [SQ_W-1:0] r_s [0:M];
	logic [TRIG_W-2:0] ax_s [0:M];
	logic sneg_s [0:M];
	logic sv_s [0:M];

	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [CW-1:0] z_s [0:N];
	logic vneg_s [0:N];
	logic vv_s [0:N];

	logic signed [CW-1:0] z_fix;

	assign z_fix = vneg_s[N] ? (PI_Q30 - z_s[N]) : z_s[N];

	always_ff @(posedge clk) begin
		if (en) begin
			csq_s1 <= cval * cval;
			ax_s1 <= cval[TRIG_W-1] ? (TRIG_W-1)'(-cval) : (TRIG_W-1)'(cval);
			neg_s1 <= cval[TRIG_W-1];
			n_s[0] <= SQ_W'((64'sd1 <<< 60) - csq_s1);
			r_s[0] <= '0;
			ax_s[0] <= ax_s1;
			sneg_s[0] <= neg_s1;
			x_s[0] <= CW'({1'b0, ax_s[M]});
			y_s[0] <= CW'({1'b0, r_s[M][TRIG_W-2:0]});
			z_s[0] <= '0;
			vneg_s[0] <= sneg_s[M];
			ang_q <= z_fix[CW-1] ? '0 : z_fix[ANGR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			sv_s[0] <= 1'b0;
			vv_s[0] <= 1'b0;
			vld_o <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_i;
			sv_s[0] <= v_s1;
			vv_s[0] <= sv_s[M];
			vld_o <= vv_s[N];
		end
	end

	// Restoring square root, one result bit per stage from the top.
	for (genvar j = 0; j < M; j++) begin : g_sqrt
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (M - 1 - j));
		logic [SQ_W-1:0] trial;

		assign trial = r_s[j] + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (n_s[j] >= trial) begin
					n_s[j+1] <= n_s[j] - trial;
					r_s[j+1] <= (r_s[j] >> 1) + BIT;
				end else begin
					n_s[j+1] <= n_s[j];
					r_s[j+1] <= r_s[j] >> 1;
				end
				ax_s[j+1] <= ax_s[j];
				sneg_s[j+1] <= sneg_s[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[j+1] <= 1'b0;
			end else if (en) begin
				sv_s[j+1] <= sv_s[j];
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(i);
				end
				vneg_s[i+1] <= vneg_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vv_s[i+1] <= 1'b0;
			end else if (en) begin
				vv_s[i+1] <= vv_s[i];
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/great_circle_distance_unit.sv =====
// Great circle distance unit: top level with the cosine-sum products and the final scaling.
// Depends on gcd_pkg, gcd_if, gcd_sincos and gcd_acos.
//
// Usage: a point pair (latitudes and longitudes in signed Q16 degrees) is offered on the
// points channel; each accepted transaction produces exactly one transaction on the
// result channel with the distance and half the distance in miles, unsigned Q8.
// The miles-per-degree factor (unsigned Q8) is written through cfg_wr_en/cfg_wr_data
// while no transaction is in flight; reset loads 90.9 miles per degree.
// The pipeline consists mostly of the two CORDIC chains and the 31-stage square root,
// each of which advances one step per register.
// Throughput is one transaction per cycle while the result channel is not stalled.
// The whole pipeline advances together; when the receiver holds ready low with a result
// waiting, every stage holds and points.ready drops, so nothing is lost or repeated.
// Reset clears all valid bits, including result.valid; payload and output data are not reset.
`default_nettype none

module great_circle_distance_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [gcd_pkg::MPD_W-1:0] cfg_wr_data,
	gcd_in_if.sink points,
	gcd_out_if.source result
);
	import gcd_pkg::*;

	logic en;
	logic [MPD_W-1:0] mpd_q;

	logic signed [ANG_W-1:0] lat1_s1, lat2_s1, dlon_s1;
	logic v_s1;

	logic signed [TRIG_W-1:0] s1, c1, s2, c2, sd, cd;
	logic v_trig, v_trig_a, v_trig_b;

	logic signed [63:0] p_ss, p_cc, p_t;
	logic signed [TRIG_W-1:0] ss_s2, cc_s2, cd_s2;
	logic v_s2;
	logic signed [TRIG_W-1:0] ss_s3, t_s3;
	logic v_s3;
	logic signed [TRIG_W:0] sum;
	logic signed [TRIG_W-1:0] c_s4;
	logic v_s4;

	logic [ANGR_W-1:0] ang;
	logic v_ang;

	logic [ANGR_W+DPR_W-1:0] p_s5;
	logic v_s5;
	logic [DEG_W-1:0] deg_s6;
	logic v_s6;
	logic [DEG_W+MPD_W-1:0] dp_s7;
	logic v_s7;
	logic [DEG_W+1:0] dd;
	logic [DIST_W-1:0] dist_q;
	logic [RADM_W-1:0] rad_q;
	logic vout_q;

	assign en = !vout_q || result.ready;
	assign points.ready = en;
	assign result.valid = vout_q;
	assign result.distance_miles = dist_q;
	assign result.radius_miles = rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpd_q <= MPD_RESET;
		end else if (cfg_wr_en) begin
			mpd_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat1_s1 <= ANG_W'(points.from_latitude);
			lat2_s1 <= ANG_W'(points.to_latitude);
			dlon_s1 <= ANG_W'(points.from_longitude) - ANG_W'(points.to_longitude);
		end
	end

	gcd_sincos u_lat1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(v_s1), .deg(lat1_s1),
		.vld_o(v_trig), .sin_q(s1), .cos_q(c1)
	);

	gcd_sincos u_lat2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(v_s1), .deg(lat2_s1),
		.vld_o(v_trig_a), .sin_q(s2), .cos_q(c2)
	);

	gcd_sincos u_dlon (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(v_s1), .deg(dlon_s1),
		.vld_o(v_trig_b), .sin_q(sd), .cos_q(cd)
	);

	// The three angle pipelines run in lockstep, so their valid bits agree and are ANDed into one.
	always_comb begin
		p_ss = s1 * s2;
		p_cc = c1 * c2;
		p_t = cc_s2 * cd_s2;
		sum = (TRIG_W+1)'(ss_s3) + (TRIG_W+1)'(t_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s2 <= TRIG_W'(p_ss >>> 30);
			cc_s2 <= TRIG_W'(p_cc >>> 30);
			cd_s2 <= cd;
			ss_s3 <= ss_s2;
			t_s3 <= TRIG_W'(p_t >>> 30);
			if (sum > (TRIG_W+1)'(ONE_Q30)) begin
				c_s4 <= TRIG_W'(ONE_Q30);
			end else if (sum < -(TRIG_W+1)'(ONE_Q30)) begin
				c_s4 <= TRIG_W'(-ONE_Q30);
			end else begin
				c_s4 <= TRIG_W'(sum);
			end
		end
	end

	gcd_acos u_acos (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(v_s4), .cval(c_s4),
		.vld_o(v_ang), .ang_q(ang)
	);

	assign dd = (DEG_W+2)'((dp_s7 + (DEG_W+MPD_W)'(32768)) >> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5 <= (ANGR_W+DPR_W)'(ang) * (ANGR_W+DPR_W)'(DEG_PER_RAD);
			deg_s6 <= DEG_W'((p_s5 + (ANGR_W+DPR_W)'(1 << 29)) >> 30);
			dp_s7 <= (DEG_W+MPD_W)'(deg_s6) * (DEG_W+MPD_W)'(mpd_q);
			dist_q <= (dd > (DEG_W+2)'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : DIST_W'(dd);
			rad_q <= ((dd >> 1) > (DEG_W+2)'({RADM_W{1'b1}})) ? {RADM_W{1'b1}}
				: RADM_W'(dd >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			vout_q <= 1'b0;
		end else if (en) begin
			v_s1 <= points.valid;
			v_s2 <= v_trig && v_trig_a && v_trig_b;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_ang;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			vout_q <= v_s7;
		end
	end

endmodule

`default_nettype wire
